// ===== rtl/qmru_pkg.sv =====
// Shared types and constants for the quadrature mouse report unit.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package qmru_pkg;

  localparam int CNT_W      = 16;  // motion counter width, 8..32
  localparam int GAIN_W     = 4;
  localparam int ADDR_W     = 4;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam int WORD_W     = 16;
  localparam int FIELD_W    = 6;   // magnitude field width in the report

  localparam logic [GAIN_W-1:0] GAIN_RST = 4'd2;
  localparam logic [ADDR_W-1:0] ADDR_RST = 4'd3;

  // command nibble for talk register 0
  localparam logic [3:0] TALK_REG0 = 4'hC;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_SPEED_GAIN     = 1'b0;
  localparam logic REG_DEVICE_ADDRESS = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic       y_a;
    logic       y_b;
    logic       x_a;
    logic       x_b;
    logic       button_n;
    logic [7:0] command;
  } in_item_t;

  typedef struct packed {
    logic              reply_valid;
    logic [WORD_W-1:0] reply_word;
    logic              service_request;
  } out_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] speed_gain;
    logic [ADDR_W-1:0] device_address;
  } cfg_t;

endpackage

// ===== rtl/quadrature_mouse_report_unit.sv =====
// Top level: input register, decoder core, result register and config port.
// Depends on qmru_pkg, qmru_cfg and qmru_core.
`timescale 1ns / 1ps

// Every accepted item produces exactly one result item. An item sits in the
// input register, where the core updates the pin/count/flag state and forms
// the report (one 16x4 multiply per axis), and is then held in the result
// register until taken. Throughput is one item per cycle while the result
// register is drained, set by the single input stage, and in_ready stays high
// while a finished result waits as long as the result register is being
// drained. Configuration registers: speed_gain at byte address 0,
// device_address at byte address 4.
module quadrature_mouse_report_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  qmru_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output qmru_pkg::out_item_t           out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qmru_pkg::PADDR_W-1:0]  paddr,
  input  logic [qmru_pkg::PDATA_W-1:0]  pwdata,
  output logic [qmru_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  qmru_pkg::cfg_t      cfg;
  qmru_pkg::in_item_t  s1_item_r;
  qmru_pkg::out_item_t core_res;
  qmru_pkg::out_item_t out_item_r;
  logic                s1_valid_r;
  logic                out_valid_r;
  logic                s1_adv;

  qmru_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qmru_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_adv),
    .item    (s1_item_r),
    .cfg     (cfg),
    .result  (core_res)
  );

  assign s1_adv   = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready)
        s1_valid_r <= in_valid;
      if (s1_adv)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid)
      s1_item_r <= in_item;
    if (s1_adv)
      out_item_r <= core_res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef ASSERT_OFF
  // a report always clears the service request
  a_reply_clears_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.reply_valid |-> !out_item.service_request)
    else $error("reply sent with service request still set");

  // no reply means an all-zero word
  a_idle_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.reply_valid |-> out_item.reply_word == '0)
    else $error("reply_word nonzero without reply_valid");

  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");
`endif

endmodule

// ===== rtl/qmru_cfg.sv =====
// Configuration registers behind the APB-style port.
// Depends on qmru_pkg.
`timescale 1ns / 1ps

module qmru_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qmru_pkg::PADDR_W-1:0]  paddr,
  input  logic [qmru_pkg::PDATA_W-1:0]  pwdata,
  output logic [qmru_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output qmru_pkg::cfg_t                cfg
);

  logic [qmru_pkg::GAIN_W-1:0] gain_r, gain_nxt;
  logic [qmru_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    gain_nxt = gain_r;
    addr_nxt = addr_r;
    if (wr_en) begin
      unique case (paddr[2])
        qmru_pkg::REG_SPEED_GAIN:     gain_nxt = pwdata[qmru_pkg::GAIN_W-1:0];
        qmru_pkg::REG_DEVICE_ADDRESS: addr_nxt = pwdata[qmru_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= qmru_pkg::GAIN_RST;
      addr_r <= qmru_pkg::ADDR_RST;
    end else begin
      gain_r <= gain_nxt;
      addr_r <= addr_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      qmru_pkg::REG_SPEED_GAIN:
        prdata = {{(qmru_pkg::PDATA_W-qmru_pkg::GAIN_W){1'b0}}, gain_r};
      qmru_pkg::REG_DEVICE_ADDRESS:
        prdata = {{(qmru_pkg::PDATA_W-qmru_pkg::ADDR_W){1'b0}}, addr_r};
      default: prdata = '0;
    endcase
  end

  assign cfg.speed_gain     = gain_r;
  assign cfg.device_address = addr_r;

endmodule

// ===== rtl/qmru_core.sv =====
// Decoder state (pins, counts, flags) and report formatting for one item.
// Depends on qmru_pkg.
`timescale 1ns / 1ps

module qmru_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  qmru_pkg::in_item_t  item,
  input  qmru_pkg::cfg_t      cfg,
  output qmru_pkg::out_item_t result
);

  localparam int CW = qmru_pkg::CNT_W;

  logic [4:0]    pins_r, pins_nxt;
  logic [CW-1:0] cnt_x_r, cnt_x_nxt;
  logic [CW-1:0] cnt_y_r, cnt_y_nxt;
  logic          press_r, press_nxt;
  logic          upd_r, upd_nxt;
  logic          req_r, req_nxt;

  logic [4:0]    pins, chg;
  logic          watched_chg;
  logic          talk;
  logic [CW-1:0] ys, xs, ys_neg;
  logic [CW+qmru_pkg::GAIN_W-1:0] ys_full, xs_full;
  logic [qmru_pkg::WORD_W-1:0]    word;

  assign pins        = {item.button_n, item.x_b, item.x_a, item.y_b, item.y_a};
  assign chg         = pins ^ pins_r;
  assign watched_chg = chg[0] | chg[2] | chg[4];

  // scaled counts wrap at the counter width
  assign ys_full = cnt_y_r * cfg.speed_gain;
  assign xs_full = cnt_x_r * cfg.speed_gain;
  assign ys      = ys_full[CW-1:0];
  assign xs      = xs_full[CW-1:0];
  assign ys_neg  = -ys;

  always_comb begin
    word     = '0;
    word[15] = ~press_r;
    if (ys != '0) begin
      word[14]   = ~ys[CW-1];
      word[13:8] = ys_neg[qmru_pkg::FIELD_W-1:0];
    end
    if (xs != '0) begin
      word[6]   = xs[CW-1];
      word[5:0] = xs[qmru_pkg::FIELD_W-1:0];
    end
  end

  always_comb begin
    pins_nxt  = pins_r;
    cnt_x_nxt = cnt_x_r;
    cnt_y_nxt = cnt_y_r;
    press_nxt = press_r;
    upd_nxt   = upd_r;
    req_nxt   = req_r;
    talk      = 1'b0;
    unique case (item.opcode)
      qmru_pkg::OP_SAMPLE: begin
        if (watched_chg) begin
          press_nxt = press_r | ~item.button_n;
          if (chg[0])
            cnt_y_nxt = cnt_y_r + ((item.y_a == item.y_b) ? CW'(1) : {CW{1'b1}});
          if (chg[2])
            cnt_x_nxt = cnt_x_r + ((item.x_a == item.x_b) ? CW'(1) : {CW{1'b1}});
          pins_nxt = pins;
          upd_nxt  = 1'b1;
        end
      end
      qmru_pkg::OP_COMMAND: begin
        if (upd_r) begin
          if (item.command[7:4] == cfg.device_address) begin
            if (item.command[3:0] == qmru_pkg::TALK_REG0) begin
              talk      = 1'b1;
              cnt_x_nxt = '0;
              cnt_y_nxt = '0;
              press_nxt = 1'b0;
              upd_nxt   = 1'b0;
              req_nxt   = 1'b0;
            end
          end else begin
            req_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pins_r  <= '0;
      cnt_x_r <= '0;
      cnt_y_r <= '0;
      press_r <= 1'b0;
      upd_r   <= 1'b0;
      req_r   <= 1'b0;
    end else if (advance) begin
      pins_r  <= pins_nxt;
      cnt_x_r <= cnt_x_nxt;
      cnt_y_r <= cnt_y_nxt;
      press_r <= press_nxt;
      upd_r   <= upd_nxt;
      req_r   <= req_nxt;
    end
  end

  assign result.reply_valid     = talk;
  assign result.reply_word      = talk ? word : '0;
  assign result.service_request = req_nxt;

endmodule

// ===== tb/qmru_report_checker.sv =====
// Scoreboard for the quadrature mouse report unit: tracks config writes, predicts
// one report per accepted item and compares it with the result channel.
// Depends on qmru_pkg.
`timescale 1ns / 1ps

module qmru_report_checker
  import qmru_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  in_item_t           in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  out_item_t          out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 mismatch_count,
  output int                 reports_outstanding
);

  logic [GAIN_W-1:0] gain_q;
  logic [ADDR_W-1:0] addr_q;
  logic              y_a_q, x_a_q, btn_q;
  logic [CNT_W-1:0]  cnt_x, cnt_y;
  logic              press_q, update_q, srq_q;
  out_item_t         expected_reports[$];

  // One decoder step: pin sample or command byte, always one result.
  // Only the A lines and the button decide anything, so only they are kept.
  task automatic advance_decoder(input in_item_t it, output out_item_t res);
    logic [CNT_W-1:0] ys, xs, ys_neg;
    logic             y_moved, x_moved;
    res = '0;
    if (it.opcode == OP_SAMPLE) begin
      y_moved = it.y_a != y_a_q;
      x_moved = it.x_a != x_a_q;
      // B lines alone never count, and such a sample leaves the stored pins alone
      if (y_moved || x_moved || (it.button_n != btn_q)) begin
        if (!it.button_n) press_q = 1'b1;
        if (y_moved) cnt_y = (it.y_a == it.y_b) ? cnt_y + 1'b1 : cnt_y - 1'b1;
        if (x_moved) cnt_x = (it.x_a == it.x_b) ? cnt_x + 1'b1 : cnt_x - 1'b1;
        y_a_q    = it.y_a;
        x_a_q    = it.x_a;
        btn_q    = it.button_n;
        update_q = 1'b1;
      end
    end else if (update_q) begin
      if (it.command[7:4] == addr_q) begin
        if (it.command[3:0] == TALK_REG0) begin
          ys     = cnt_y * CNT_W'(gain_q);
          xs     = cnt_x * CNT_W'(gain_q);
          ys_neg = -ys;
          res.reply_valid    = 1'b1;
          res.reply_word[15] = !press_q;
          if (ys != '0) begin
            res.reply_word[14]  = !ys[CNT_W-1];
            res.reply_word[13:8] = ys_neg[FIELD_W-1:0];
          end
          if (xs != '0) begin
            res.reply_word[6]   = xs[CNT_W-1];
            res.reply_word[5:0] = xs[FIELD_W-1:0];
          end
          cnt_x    = '0;
          cnt_y    = '0;
          press_q  = 1'b0;
          update_q = 1'b0;
          srq_q    = 1'b0;
        end
      end else begin
        srq_q = 1'b1;
      end
    end
    res.service_request = srq_q;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      gain_q   = GAIN_RST;
      addr_q   = ADDR_RST;
      {y_a_q, x_a_q, btn_q} = '0;
      cnt_x    = '0;
      cnt_y    = '0;
      press_q  = 1'b0;
      update_q = 1'b0;
      srq_q    = 1'b0;
      expected_reports.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_SPEED_GAIN:     gain_q = pwdata[GAIN_W-1:0];
          REG_DEVICE_ADDRESS: addr_q = pwdata[ADDR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        advance_decoder(in_item, want);
        expected_reports.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected report: valid=%0b word=%04h srq=%0b", $time,
                     out_item.reply_valid, out_item.reply_word, out_item.service_request);
        end else begin
          want = expected_reports.pop_front();
          if ((out_item.reply_valid !== want.reply_valid) ||
              (out_item.reply_word !== want.reply_word) ||
              (out_item.service_request !== want.service_request)) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: expected v=%0b w=%04h sr=%0b, got v=%0b w=%04h sr=%0b",
                       $time, want.reply_valid, want.reply_word, want.service_request,
                       out_item.reply_valid, out_item.reply_word, out_item.service_request);
          end
        end
      end
    end
    reports_outstanding = expected_reports.size();
  end

endmodule

// ===== tb/tb_quadrature_mouse_report_unit.sv =====
// Testbench top for the quadrature mouse report unit: clock, reset, encoder and
// command traffic, config writes and the verdict. Depends on qmru_pkg, the DUT
// and qmru_report_checker.
`timescale 1ns / 1ps

module tb_quadrature_mouse_report_unit;
  import qmru_pkg::*;

  localparam logic [3:0] FLUSH_CMD = 4'h1;  // a non-talk command nibble
  localparam int         IN_W      = $bits(in_item_t);

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_item;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int                 mismatch_count;
  int                 reports_outstanding;
  int                 items_sent;
  bit                 idle_on;
  bit                 hold_off_req;
  logic [ADDR_W-1:0]  cur_addr;
  in_item_t           pin_state;  // only the pin fields are used

  quadrature_mouse_report_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  qmru_report_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatch_count(mismatch_count), .reports_outstanding(reports_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("Mismatches found");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (40) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic in_item_t sample_item();
    in_item_t it;
    it          = pin_state;
    it.opcode   = OP_SAMPLE;
    it.command  = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic in_item_t command_item(input logic [7:0] cmd);
    in_item_t it;
    logic [4:0] junk;
    junk    = 5'($urandom_range(0, 31));
    it      = '0;
    it.opcode = OP_COMMAND;
    {it.y_a, it.y_b, it.x_a, it.x_b, it.button_n} = junk;
    it.command = cmd;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_DEVICE_ADDRESS) cur_addr = val;
    @(posedge clk);
  endtask

  // one gray-code step on an axis; every other step moves the A line
  task automatic move_axis(input bit on_x, input bit up);
    logic [1:0] ph;
    ph = on_x ? {pin_state.x_a, pin_state.x_a ^ pin_state.x_b}
              : {pin_state.y_a, pin_state.y_a ^ pin_state.y_b};
    ph = up ? ph + 2'd1 : ph - 2'd1;
    if (on_x) begin
      pin_state.x_a = ph[1];
      pin_state.x_b = ph[1] ^ ph[0];
    end else begin
      pin_state.y_a = ph[1];
      pin_state.y_b = ph[1] ^ ph[0];
    end
    send_item(sample_item());
  endtask

  // motion, maybe button, then the host usually polls
  task automatic mouse_session();
    int  steps;
    bit  up_x, up_y;
    steps = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
    up_x  = 1'($urandom_range(0, 1));
    up_y  = 1'($urandom_range(0, 1));
    repeat (steps) begin
      if ($urandom_range(0, 7) == 0) begin
        up_x = !up_x;
        up_y = !up_y;
      end
      if ($urandom_range(0, 5) == 0) begin
        pin_state.button_n = !pin_state.button_n;
        send_item(sample_item());
      end else begin
        move_axis(1'($urandom_range(0, 1)), $urandom_range(0, 1) ? up_x : up_y);
      end
    end
    if ($urandom_range(0, 3) == 0)
      send_item(command_item({cur_addr + 4'($urandom_range(1, 15)), 4'($urandom_range(0, 15))}));
    if ($urandom_range(0, 5) == 0)
      send_item(command_item({cur_addr, TALK_REG0 + 4'($urandom_range(1, 15))}));
    if ($urandom_range(0, 7) != 0)
      send_item(command_item({cur_addr, TALK_REG0}));
    if ($urandom_range(0, 7) == 0)
      send_item(command_item({cur_addr, TALK_REG0}));  // nothing pending now if the poll above was sent
  endtask

  task automatic random_traffic(input int n_items, input bit squeeze);
    int start;
    logic [IN_W-1:0] raw;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if (squeeze && items_sent - start > n_items / 2) begin
        hold_off_req = 1'b1;
        squeeze      = 1'b0;
      end
      if ($urandom_range(0, 9) < 7) begin
        mouse_session();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          raw = IN_W'($urandom);
          send_item(in_item_t'(raw));
        end
      end
    end
  endtask

  initial begin
    in_valid     <= 1'b0;
    in_item      <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    rst_n        <= 1'b0;
    idle_on      = 1'b1;
    hold_off_req = 1'b0;
    items_sent   = 0;
    cur_addr     = ADDR_RST;
    pin_state    = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset config
    send_item(command_item({cur_addr, TALK_REG0}));          // nothing pending
    send_item(command_item({cur_addr + 4'd1, TALK_REG0}));   // nothing pending
    send_item(sample_item());                                // pins unchanged
    pin_state.y_b = 1'b1;
    send_item(sample_item());                                // B line only
    pin_state.x_b = 1'b1;
    send_item(sample_item());
    pin_state.y_a      = 1'b1;
    pin_state.button_n = 1'b0;
    send_item(sample_item());                                // press and Y step
    send_item(command_item({cur_addr, FLUSH_CMD}));          // own address, not talk
    send_item(command_item(8'hFF));                          // raises service request
    send_item(command_item(8'h00));
    send_item(command_item({cur_addr, TALK_REG0}));
    pin_state.button_n = 1'b1;
    pin_state.x_a      = 1'b1;
    send_item(sample_item());
    send_item(command_item({cur_addr, TALK_REG0}));
    pin_state = '1;
    send_item(sample_item());
    pin_state = '0;
    send_item(sample_item());
    send_item(command_item({cur_addr, TALK_REG0}));
    repeat (4) move_axis(1'b0, 1'b0);
    repeat (4) move_axis(1'b1, 1'b0);
    send_item(command_item({cur_addr, TALK_REG0}));

    wait_idle();
    write_reg(REG_SPEED_GAIN, 4'd1);
    write_reg(REG_DEVICE_ADDRESS, 4'd0);
    random_traffic(150, 1'b0);

    wait_idle();
    write_reg(REG_SPEED_GAIN, 4'd15);
    write_reg(REG_DEVICE_ADDRESS, 4'd15);
    random_traffic(150, 1'b1);

    wait_idle();
    write_reg(REG_SPEED_GAIN, 4'($urandom_range(1, 15)));
    write_reg(REG_DEVICE_ADDRESS, 4'($urandom_range(0, 15)));
    random_traffic(150, 1'b0);

    idle_on = 1'b0;
    wait_idle();
    write_reg(REG_SPEED_GAIN, 4'd0);
    write_reg(REG_DEVICE_ADDRESS, 4'($urandom_range(0, 15)));
    random_traffic(100, 1'b0);

    // report fields wrap: X climbs, Y falls, one count per sample
    wait_idle();
    write_reg(REG_SPEED_GAIN, 4'd15);
    repeat (60) begin
      pin_state.y_a = !pin_state.y_a;
      pin_state.y_b = !pin_state.y_a;
      pin_state.x_a = !pin_state.x_a;
      pin_state.x_b = pin_state.x_a;
      send_item(sample_item());
    end
    send_item(command_item({cur_addr, TALK_REG0}));

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && reports_outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
